### src/kcl_pkg.sv
// Package for the keypad code lock: constants, codes, state and result types.
`default_nettype none

package kcl_pkg;

	localparam int CODE_LEN   = 4;
	localparam int POS_W      = $clog2(CODE_LEN + 1);
	localparam int KEY_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int DIGITS_W   = 3;
	localparam int FAIL_W     = 4;
	localparam int CODE_W     = 32;
	localparam int CODE_BYTES = CODE_W / KEY_W;

	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int REG_SEL_BIT = 2;

	typedef logic [KEY_W-1:0] char_t;

	localparam char_t CHAR_FILLER = 8'h30;
	localparam char_t KEY_NONE    = 8'h00;
	localparam char_t KEY_ENTER   = 8'h2A;
	localparam char_t KEY_BACK    = 8'h23;

	localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

	localparam logic [CODE_W-1:0] CODE_WORD_RST    = 32'h3139_3938;
	localparam logic [FAIL_W-1:0] MAX_FAILURES_RST = 4'd3;

	typedef enum logic {
		REG_CODE_WORD,
		REG_MAX_FAILURES
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_ENTERING,
		MODE_UNLOCKED,
		MODE_BLOCKED
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_NONE,
		STAT_CORRECT,
		STAT_INCORRECT,
		STAT_BLOCKED
	} status_t;

	typedef struct packed {
		status_t              status;
		logic                 unlocked;
		logic [DIGITS_W-1:0]  digits_entered;
		logic [FAIL_W-1:0]    failures;
	} result_t;

endpackage

`default_nettype wire

### src/kcl_if.sv
// Valid/ready stream interfaces for key items and result items.
`default_nettype none

interface kcl_key_if;
	import kcl_pkg::*;
	logic  valid;
	logic  ready;
	char_t key_char;

	modport source (output valid, output key_char, input ready);
	modport sink (input valid, input key_char, output ready);
endinterface

interface kcl_result_if;
	import kcl_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                unlocked;
	logic [DIGITS_W-1:0] digits_entered;
	logic [FAIL_W-1:0]   failures;

	modport source (output valid, output status, output unlocked, output digits_entered,
		output failures, input ready);
	modport sink (input valid, input status, input unlocked, input digits_entered,
		input failures, output ready);
endinterface

`default_nettype wire

### src/kcl_core.sv
// Lock state: entered characters, position, failure count and mode, updated once per item.
`default_nettype none

module kcl_core import kcl_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire char_t               key_char,
	input  wire logic [CODE_W-1:0]   code_word,
	input  wire logic [FAIL_W-1:0]   max_failures,
	output result_t                  res
);

	char_t             chars_q [CODE_LEN];
	char_t             chars_d [CODE_LEN];
	char_t             expected [CODE_LEN];
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [FAIL_W-1:0] fail_q, fail_d, fail_inc;
	mode_t             mode_q, mode_d;
	logic              match, limit_hit;
	logic              is_none, is_enter, is_back;

	genvar gp;
	for (gp = 0; gp < CODE_LEN; gp++) begin : g_exp
		if (gp < CODE_BYTES) begin : g_byte
			assign expected[gp] = code_word[CODE_W-KEY_W*(gp+1) +: KEY_W];
		end else begin : g_fill
			assign expected[gp] = CHAR_FILLER;
		end
	end

	always_comb begin
		match = 1'b1;
		for (int p = 0; p < CODE_LEN; p++) begin
			if (chars_q[p] != expected[p]) match = 1'b0;
		end
	end

	assign is_none   = (key_char == KEY_NONE);
	assign is_enter  = (key_char == KEY_ENTER);
	assign is_back   = (key_char == KEY_BACK);
	assign fail_inc  = (fail_q != FAIL_MAX) ? fail_q + 1'b1 : fail_q;
	assign limit_hit = (fail_inc >= max_failures);

	// Next state.
	always_comb begin
		chars_d = chars_q;
		pos_d   = pos_q;
		fail_d  = fail_q;
		mode_d  = mode_q;
		case (mode_q)
			MODE_ENTERING: begin
				if (is_none) begin
					mode_d = mode_q;
				end else if (is_enter) begin
					if (match) begin
						mode_d = MODE_UNLOCKED;
						fail_d = '0;
					end else begin
						fail_d = fail_inc;
						pos_d  = '0;
						for (int i = 0; i < CODE_LEN; i++) chars_d[i] = CHAR_FILLER;
						if (limit_hit) mode_d = MODE_BLOCKED;
					end
				end else if (is_back) begin
					if (pos_q != '0) begin
						pos_d = pos_q - 1'b1;
						for (int i = 0; i < CODE_LEN; i++) begin
							if (POS_W'(i) == pos_d) chars_d[i] = CHAR_FILLER;
						end
					end
				end else begin
					if (pos_q < POS_W'(CODE_LEN)) begin
						pos_d = pos_q + 1'b1;
						for (int i = 0; i < CODE_LEN; i++) begin
							if (POS_W'(i) == pos_q) chars_d[i] = key_char;
						end
					end
				end
			end
			MODE_UNLOCKED: begin
				if (is_enter) begin
					mode_d = MODE_ENTERING;
					pos_d  = '0;
					for (int i = 0; i < CODE_LEN; i++) chars_d[i] = CHAR_FILLER;
				end
			end
			MODE_BLOCKED: begin
				mode_d = MODE_BLOCKED;
			end
			default: begin
				mode_d = MODE_ENTERING;
			end
		endcase
	end

	// Result of the item.
	always_comb begin
		res.status = STAT_NONE;
		case (mode_q)
			MODE_BLOCKED: begin
				res.status = STAT_BLOCKED;
			end
			MODE_ENTERING: begin
				if (is_enter) begin
					if (match) res.status = STAT_CORRECT;
					else if (limit_hit) res.status = STAT_BLOCKED;
					else res.status = STAT_INCORRECT;
				end
			end
			default: begin
				res.status = STAT_NONE;
			end
		endcase
		res.unlocked       = (mode_d == MODE_UNLOCKED);
		res.digits_entered = DIGITS_W'(pos_d);
		res.failures       = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CODE_LEN; i++) chars_q[i] <= CHAR_FILLER;
			pos_q  <= '0;
			fail_q <= '0;
			mode_q <= MODE_ENTERING;
		end else if (fire) begin
			chars_q <= chars_d;
			pos_q   <= pos_d;
			fail_q  <= fail_d;
			mode_q  <= mode_d;
		end
	end

	// Once blocked, only reset frees the lock.
	a_blocked_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_BLOCKED |=> mode_q == MODE_BLOCKED)
		else $error("blocked lock left the blocked mode");

	// An open lock has no failures counted.
	a_unlocked_no_fail: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_UNLOCKED |-> fail_q == '0)
		else $error("failure count nonzero while unlocked");

	// The position never runs past the code length.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(CODE_LEN))
		else $error("entry position beyond code length");

	// The failure count only steps up by one or clears.
	a_fail_step: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q != $past(fail_q) |-> fail_q == $past(fail_q) + 1'b1 || fail_q == '0)
		else $error("failure count jumped");

endmodule

`default_nettype wire

### src/keypad_code_lock.sv
// Top level of the keypad code lock: item streams, APB register port and lock core.
`default_nettype none

// Each key item gives exactly one result item. The block takes one item per clock cycle
// while results are taken. The key is held in the input register while the lock state is
// worked out, and the result then waits in the result register. A stalled result holds
// the result register, the input register then fills and key ready drops. Registers:
// code_word at byte address 0 (first code character in the top byte), max_failures at
// byte address 4 (bits 3:0). Write them only while no item is in flight. When the
// failure count reaches max_failures the lock reports blocked on every item until reset.
module keypad_code_lock import kcl_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	kcl_key_if.sink                     key,
	kcl_result_if.source                res,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [APB_ADDR_W-1:0]  paddr,
	input  wire logic [APB_DATA_W-1:0]  pwdata,
	output logic      [APB_DATA_W-1:0]  prdata,
	output logic                        pready
);

	logic              valid_s1;
	char_t             key_s1;
	logic              out_valid_q;
	result_t           out_res_q;
	result_t           core_res;
	logic              advance;
	logic              cfg_wr;
	reg_idx_t          reg_sel;
	logic [CODE_W-1:0] code_word_q;
	logic [FAIL_W-1:0] max_failures_q;

	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign key.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key.ready) begin
			valid_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key.valid && key.ready) key_s1 <= key.key_char;
	end

	kcl_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.key_char     (key_s1),
		.code_word    (code_word_q),
		.max_failures (max_failures_q),
		.res          (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_res_q <= core_res;
	end

	assign res.valid          = out_valid_q;
	assign res.status         = out_res_q.status;
	assign res.unlocked       = out_res_q.unlocked;
	assign res.digits_entered = out_res_q.digits_entered;
	assign res.failures       = out_res_q.failures;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[REG_SEL_BIT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_word_q    <= CODE_WORD_RST;
			max_failures_q <= MAX_FAILURES_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_CODE_WORD: begin
					code_word_q <= pwdata[CODE_W-1:0];
				end
				REG_MAX_FAILURES: begin
					max_failures_q <= pwdata[FAIL_W-1:0];
				end
				default: begin
					code_word_q <= code_word_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_CODE_WORD: begin
				prdata = APB_DATA_W'(code_word_q);
			end
			REG_MAX_FAILURES: begin
				prdata = APB_DATA_W'(max_failures_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

`default_nettype wire
